FILE: sv/skf_pkg.sv
// ----------------------------------------------------------------------------
// skf_pkg
// Shared constants, register indexes and sequencer states of the scalar
// Kalman filter unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package skf_pkg;

  localparam int SKF_SAMPLE_WIDTH = 16;

  // configuration port
  localparam int SKF_CFG_AW = 2;
  localparam int SKF_CFG_DW = 32;

  typedef enum logic [SKF_CFG_AW-1:0] {
    REG_STATE_GAIN    = 2'd0,
    REG_PROCESS_NOISE = 2'd1,
    REG_MEAS_NOISE    = 2'd2
  } skf_reg_t;

  localparam logic signed [15:0] SKF_GAIN_RST  = 16'sd4096;
  localparam logic [31:0]        SKF_QNOISE_RST = 32'd65536;
  localparam logic [31:0]        SKF_RNOISE_RST = 32'd65536;

  // divider produces quotient bits 16 down to 0
  localparam int SKF_DIV_STEPS = 17;
  localparam int SKF_CNT_W     = $clog2(SKF_DIV_STEPS);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_AX,
    ST_MUL_AA,
    ST_MUL_AAP,
    ST_PRED_P,
    ST_DIV_INIT,
    ST_DIV,
    ST_MUL_KLO,
    ST_MUL_KHI,
    ST_MUL_KP,
    ST_FINISH
  } skf_state_t;

endpackage

`default_nettype wire

FILE: sv/skf_if.sv
// ----------------------------------------------------------------------------
// skf_if
// Valid/ready stream interfaces for measurement samples and filtered values.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface skf_meas_if #(
  parameter int W = 16
);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] measurement;

  modport source (output valid, output measurement, input ready);
  modport sink   (input valid, input measurement, output ready);
endinterface

interface skf_filt_if #(
  parameter int W = 16
);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] filtered_value;

  modport source (output valid, output filtered_value, input ready);
  modport sink   (input valid, input filtered_value, output ready);
endinterface

`default_nettype wire

FILE: sv/scalar_kalman_filter_unit.sv
// ----------------------------------------------------------------------------
// scalar_kalman_filter_unit
// One-dimensional Kalman filter: predict, gain by restoring division, update.
// ----------------------------------------------------------------------------
// a request is taken only in the idle state, so one request is in flight at a time;
//   each goes through the 17-step restoring gain divider and six passes through
//   the single shared 33x33 multiplier
// a result waits in the output register; the next request is taken meanwhile
// reset (rst_n low, synchronous): estimate and covariance cleared, registers
//   back to A = 1.0, Q = R = 1.0, output register emptied
`timescale 1ns / 1ps
`default_nettype none

module scalar_kalman_filter_unit #(
  parameter int SAMPLE_WIDTH = skf_pkg::SKF_SAMPLE_WIDTH
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  skf_meas_if.sink                             in_chan,
  skf_filt_if.source                           out_chan,
  input  wire logic                            cfg_we,
  input  wire logic [skf_pkg::SKF_CFG_AW-1:0]  cfg_addr,
  input  wire logic [skf_pkg::SKF_CFG_DW-1:0]  cfg_wdata
);
  import skf_pkg::*;

  localparam int SW  = SAMPLE_WIDTH;
  // difference z*2^16 - x_pred, split at bit 24 for two partial products
  localparam int DW  = ((SW + 16 > 32) ? SW + 16 : 32) + 1;
  localparam int LOW = 24;
  localparam int RW  = ((SW > 17) ? SW : 17) + 1;
  localparam logic signed [RW-1:0] YMAX = RW'((64'sd1 <<< (SW - 1)) - 64'sd1);
  localparam logic signed [RW-1:0] YMIN = RW'(-(64'sd1 <<< (SW - 1)));

  skf_state_t state_r, state_nxt;

  // configuration
  logic signed [15:0] gain_a_r;
  logic [31:0]        qn_r;
  logic [31:0]        rn_r;

  // filter state
  logic signed [31:0] est_r;
  logic [31:0]        cov_r;

  // working registers
  logic signed [SW-1:0]  z_r;
  logic signed [65:0]    prod_r;
  logic signed [31:0]    xp_r;
  logic signed [DW-1:0]  diff_r;
  logic [31:0]           pp_r;
  logic [32:0]           den_r;
  logic [33:0]           rem_r;
  logic [16:0]           quo_r;
  logic [SKF_CNT_W-1:0]  cnt_r;
  logic signed [65:0]    acc_r;
  logic                  out_valid_r;
  logic signed [SW-1:0]  out_data_r;

  // shared multiplier
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_p;
  assign mul_p = mul_a * mul_b;

  logic in_fire, fin_fire;
  assign in_chan.ready = (state_r == ST_IDLE);
  assign in_fire       = in_chan.valid && in_chan.ready;
  assign fin_fire      = (state_r == ST_FINISH) && (!out_valid_r || out_chan.ready);

  assign out_chan.valid          = out_valid_r;
  assign out_chan.filtered_value = out_data_r;

  // gain is zero when the denominator is zero
  logic [16:0] gain;
  assign gain = (den_r == 33'd0) ? 17'd0 : quo_r;

  // predicted estimate
  logic signed [47:0] ax_rnd;
  logic signed [35:0] ax_sh;
  logic signed [31:0] xp_nxt;
  always_comb begin
    ax_rnd = prod_r[47:0] + 48'sd2048;
    ax_sh  = ax_rnd[47:12];
    if (ax_sh > 36'sd2147483647) begin
      xp_nxt = 32'sh7FFFFFFF;
    end else if (ax_sh < -36'sd2147483648) begin
      xp_nxt = 32'sh80000000;
    end else begin
      xp_nxt = ax_sh[31:0];
    end
  end

  // predicted covariance
  logic [62:0] aap_rnd;
  logic [39:0] pp_sum;
  logic [31:0] pp_nxt;
  always_comb begin
    aap_rnd = prod_r[62:0] + 63'd8388608;
    pp_sum  = 40'(aap_rnd[62:24]) + 40'(qn_r);
    pp_nxt  = (pp_sum > 40'hFFFFFFFF) ? 32'hFFFFFFFF : pp_sum[31:0];
  end

  // one restoring division step
  logic [34:0] trial;
  logic        ge;
  logic [33:0] rem_step;
  always_comb begin
    trial    = {1'b0, rem_r} - {2'b00, den_r};
    ge       = !trial[34];
    rem_step = ge ? {trial[32:0], 1'b0} : {rem_r[32:0], 1'b0};
  end

  // estimate and covariance update and output rounding
  logic signed [65:0] acc_rnd;
  logic signed [49:0] corr;
  logic signed [50:0] xsum;
  logic signed [31:0] xnew;
  logic signed [32:0] y_rnd;
  logic signed [RW-1:0] yw;
  logic signed [RW-1:0] ysat;
  logic [48:0] pn_rnd;
  logic [31:0] pnew;
  always_comb begin
    acc_rnd = acc_r + 66'sd32768;
    corr    = acc_rnd[65:16];
    xsum    = 51'(corr) + 51'(xp_r);
    if (xsum > 51'sd2147483647) begin
      xnew = 32'sh7FFFFFFF;
    end else if (xsum < -51'sd2147483648) begin
      xnew = 32'sh80000000;
    end else begin
      xnew = xsum[31:0];
    end
    y_rnd = 33'(xnew) + 33'sd32768;
    // rounded value is signed, extend with its sign
    yw    = RW'($signed(y_rnd[32:16]));
    if (yw > YMAX) begin
      ysat = YMAX;
    end else if (yw < YMIN) begin
      ysat = YMIN;
    end else begin
      ysat = yw;
    end
    pn_rnd = {1'b0, prod_r[47:0]} + 49'd32768;
    pnew   = pn_rnd[47:16];
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:     if (in_fire) state_nxt = ST_MUL_AX;
      ST_MUL_AX:   state_nxt = ST_MUL_AA;
      ST_MUL_AA:   state_nxt = ST_MUL_AAP;
      ST_MUL_AAP:  state_nxt = ST_PRED_P;
      ST_PRED_P:   state_nxt = ST_DIV_INIT;
      ST_DIV_INIT: state_nxt = ST_DIV;
      ST_DIV:      if (cnt_r == '0) state_nxt = ST_MUL_KLO;
      ST_MUL_KLO:  state_nxt = ST_MUL_KHI;
      ST_MUL_KHI:  state_nxt = ST_MUL_KP;
      ST_MUL_KP:   state_nxt = ST_FINISH;
      ST_FINISH:   if (fin_fire) state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // multiplier operand selection
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      ST_MUL_AX: begin
        mul_a = 33'(gain_a_r);
        mul_b = 33'(est_r);
      end
      ST_MUL_AA: begin
        mul_a = 33'(gain_a_r);
        mul_b = 33'(gain_a_r);
      end
      ST_MUL_AAP: begin
        // A*A is at most 2^30, so bit 32 of the product is clear
        mul_a = prod_r[32:0];
        mul_b = {1'b0, cov_r};
      end
      ST_MUL_KLO: begin
        mul_a = {16'd0, gain};
        mul_b = {{(33 - LOW){1'b0}}, diff_r[LOW-1:0]};
      end
      ST_MUL_KHI: begin
        mul_a = {16'd0, gain};
        mul_b = {{(33 - DW + LOW){diff_r[DW-1]}}, diff_r[DW-1:LOW]};
      end
      ST_MUL_KP: begin
        mul_a = {16'd0, 17'(17'h10000 - gain)};
        mul_b = {1'b0, pp_r};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      gain_a_r    <= SKF_GAIN_RST;
      qn_r        <= SKF_QNOISE_RST;
      rn_r        <= SKF_RNOISE_RST;
      est_r       <= '0;
      cov_r       <= '0;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      state_r <= state_nxt;

      if (cfg_we) begin
        case (cfg_addr)
          REG_STATE_GAIN:    gain_a_r <= cfg_wdata[15:0];
          REG_PROCESS_NOISE: qn_r     <= cfg_wdata;
          REG_MEAS_NOISE:    rn_r     <= cfg_wdata;
          default:           ;
        endcase
      end

      if (state_r == ST_DIV_INIT) begin
        cnt_r <= SKF_CNT_W'(SKF_DIV_STEPS - 1);
      end else if (state_r == ST_DIV) begin
        cnt_r <= cnt_r - 1'b1;
      end

      if (fin_fire) begin
        est_r <= xnew;
        cov_r <= pnew;
      end

      out_valid_r <= (out_valid_r && !out_chan.ready) || fin_fire;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      z_r <= in_chan.measurement;
    end
    case (state_r)
      ST_MUL_AX, ST_MUL_AA, ST_MUL_AAP, ST_MUL_KLO, ST_MUL_KHI, ST_MUL_KP: begin
        prod_r <= mul_p;
      end
      default: ;
    endcase
    case (state_r)
      ST_MUL_AA:   xp_r   <= xp_nxt;
      ST_MUL_AAP:  diff_r <= (DW'(z_r) <<< 16) - DW'(xp_r);
      ST_PRED_P:   pp_r   <= pp_nxt;
      ST_DIV_INIT: begin
        den_r <= {1'b0, pp_r} + {1'b0, rn_r};
        rem_r <= {2'b00, pp_r};
      end
      ST_DIV: begin
        rem_r <= rem_step;
        quo_r <= {quo_r[15:0], ge};
      end
      ST_MUL_KHI:  acc_r  <= prod_r;
      ST_MUL_KP:   acc_r  <= acc_r + (prod_r <<< LOW);
      default: ;
    endcase
    if (fin_fire) begin
      out_data_r <= ysat[SW-1:0];
    end
  end

  // covariance never grows in the update
  a_cov_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    fin_fire |-> (pnew <= pp_r))
    else $error("updated covariance exceeds predicted covariance");

  // gain is at most 1.0 once division is done
  a_gain_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MUL_KLO) |-> (gain <= 17'h10000))
    else $error("gain above 1.0");

  // a zero denominator only with zero predicted covariance
  a_den_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV && den_r == 33'd0) |-> (pp_r == 32'd0))
    else $error("zero denominator with non-zero covariance");

  // a result appears only from the finishing step
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ST_FINISH))
    else $error("output valid without a finished request");

endmodule

`default_nettype wire
